// ===== src/fppu_pkg.sv =====
// Package for the perspective projector: payload structs, constants, queue entry type.
// No dependencies.
package fppu_pkg;

   localparam int unsigned QShift    = 12;
   localparam int unsigned NumWidth  = 48;
   localparam int unsigned DenWidth  = 32;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 48;

   localparam logic [31:0] CenterU = 32'd160;
   localparam logic [31:0] CenterV = 32'd120;
   localparam logic signed [31:0] MinDepth = 32'sd1;

   localparam logic [CsrIdxW-1:0] RegRow0   = 3'd0;
   localparam logic [CsrIdxW-1:0] RegRow1   = 3'd1;
   localparam logic [CsrIdxW-1:0] RegRow2   = 3'd2;
   localparam logic [CsrIdxW-1:0] RegOffX   = 3'd3;
   localparam logic [CsrIdxW-1:0] RegOffY   = 3'd4;
   localparam logic [CsrIdxW-1:0] RegOffZ   = 3'd5;
   localparam logic [CsrIdxW-1:0] RegDist   = 3'd6;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic signed [31:0] screen_u;
      logic signed [31:0] screen_v;
   } rsp_type;

   // classified work handed from front to back
   typedef struct packed {
      logic                       visible;
      logic signed [NumWidth-1:0] num_u;
      logic signed [NumWidth-1:0] num_v;
      logic        [DenWidth-1:0] depth;
   } work_type;

   // queue status between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== src/fppu_front.sv =====
// Front end: register file, matrix rotate, offset, visibility test, numerators.
// Depends on fppu_pkg.
module fppu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [fppu_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fppu_pkg::CsrDataW-1:0] csr_wdata,
   input  logic                     in_valid,
   input  fppu_pkg::req_type        in_data,
   input  logic                     advance,
   output logic                     out_valid,
   output fppu_pkg::work_type       out_data
);
   import fppu_pkg::*;

   logic [47:0] row_ff [3];
   logic [31:0] off_ff [3];
   logic [15:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= 48'h000000001000;
         row_ff[1] <= 48'h000010000000;
         row_ff[2] <= 48'h100000000000;
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= '0;
         dist_ff   <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            RegRow0: row_ff[0] <= csr_wdata;
            RegRow1: row_ff[1] <= csr_wdata;
            RegRow2: row_ff[2] <= csr_wdata;
            RegOffX: off_ff[0] <= csr_wdata[31:0];
            RegOffY: off_ff[1] <= csr_wdata[31:0];
            RegOffZ: off_ff[2] <= csr_wdata[31:0];
            RegDist: dist_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // stage 1: nine products
   logic               v1_ff;
   logic signed [47:0] prod_ff [3][3];
   // stage 2: camera coordinates
   logic               v2_ff;
   logic signed [31:0] cam_ff [3];
   // stage 3: numerators
   logic               v3_ff;
   work_type           w3_ff;

   logic signed [31:0] pt [3];
   assign pt[0] = in_data.point_x;
   assign pt[1] = in_data.point_y;
   assign pt[2] = in_data.point_z;

   logic signed [49:0] sum [3];
   logic signed [37:0] shd [3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum[r] = 50'(prod_ff[r][0]) + 50'(prod_ff[r][1]) + 50'(prod_ff[r][2]);
         shd[r] = 38'(sum[r] >>> QShift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               prod_ff[r][k] <= 48'($signed(row_ff[r][16*k +: 16]) * pt[k]);
         for (int r = 0; r < 3; r++)
            cam_ff[r] <= shd[r][31:0] + off_ff[r];
         w3_ff.visible <= cam_ff[2] > MinDepth;
         w3_ff.num_u   <= 48'(cam_ff[0] * $signed({1'b0, dist_ff}));
         w3_ff.num_v   <= 48'(cam_ff[1] * $signed({1'b0, dist_ff}));
         w3_ff.depth   <= cam_ff[2];
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = w3_ff;
endmodule

// ===== src/fppu_queue.sv =====
// Short FIFO between front and back ends.
// Depends on fppu_pkg.
module fppu_queue #(
   parameter int unsigned Depth = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fppu_pkg::work_type push_data,
   input  logic               pop,
   output fppu_pkg::work_type pop_data,
   output fppu_pkg::qstat_type stat,
   output logic [$clog2(Depth+1)-1:0] count
);
   import fppu_pkg::*;
   localparam int unsigned AW = $clog2(Depth);

   work_type              mem_ff [Depth];
   logic [AW-1:0]         wr_ff, rd_ff;
   logic [$clog2(Depth+1)-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data   = mem_ff[rd_ff];
   assign stat.full  = cnt_ff == ($clog2(Depth+1))'(Depth);
   assign stat.empty = cnt_ff == '0;
   assign count      = cnt_ff;

   assert property (@(posedge clock) disable iff (reset) !(push && stat.full && !pop))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) !(pop && stat.empty))
      else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count");
endmodule

// ===== src/fppu_divider.sv =====
// Pipelined signed divider, one quotient bit per stage, 48-bit numerator over positive depth.
// Depends on fppu_pkg.
module fppu_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  fppu_pkg::work_type              in_data,
   output logic                            out_valid,
   output fppu_pkg::rsp_type               out_data
);
   import fppu_pkg::*;
   localparam int unsigned N = NumWidth;

   typedef struct packed {
      logic          visible;
      logic          neg_u, neg_v;
      logic [N-1:0]  qu, qv;
      logic [DenWidth:0] ru, rv;
      logic [DenWidth-1:0] den;
   } stage_type;

   logic      v_ff [N+1];
   stage_type s_ff [N+1];
   stage_type s_in [N+1];

   always_comb begin
      s_in[0].visible = in_data.visible;
      s_in[0].neg_u   = in_data.num_u[N-1];
      s_in[0].neg_v   = in_data.num_v[N-1];
      s_in[0].qu      = in_data.num_u[N-1] ? -in_data.num_u : in_data.num_u;
      s_in[0].qv      = in_data.num_v[N-1] ? -in_data.num_v : in_data.num_v;
      s_in[0].ru      = '0;
      s_in[0].rv      = '0;
      s_in[0].den     = in_data.depth;
      for (int i = 1; i <= N; i++) begin
         logic [DenWidth:0] tu, tv;
         s_in[i] = s_ff[i-1];
         tu = {s_ff[i-1].ru[DenWidth-1:0], s_ff[i-1].qu[N-1]};
         tv = {s_ff[i-1].rv[DenWidth-1:0], s_ff[i-1].qv[N-1]};
         s_in[i].qu = {s_ff[i-1].qu[N-2:0], tu >= {1'b0, s_ff[i-1].den}};
         s_in[i].qv = {s_ff[i-1].qv[N-2:0], tv >= {1'b0, s_ff[i-1].den}};
         s_in[i].ru = (tu >= {1'b0, s_ff[i-1].den}) ? tu - {1'b0, s_ff[i-1].den} : tu;
         s_in[i].rv = (tv >= {1'b0, s_ff[i-1].den}) ? tv - {1'b0, s_ff[i-1].den} : tv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= N; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= N; i++) s_ff[i] <= s_in[i];
      end
   end

   logic [N-1:0] qu_s, qv_s;
   assign qu_s = s_ff[N].neg_u ? -s_ff[N].qu : s_ff[N].qu;
   assign qv_s = s_ff[N].neg_v ? -s_ff[N].qv : s_ff[N].qv;

   assign out_valid         = v_ff[N];
   assign out_data.visible  = s_ff[N].visible;
   assign out_data.screen_u = s_ff[N].visible ? qu_s[31:0] + CenterU : '0;
   assign out_data.screen_v = s_ff[N].visible ? qv_s[31:0] + CenterV : '0;
endmodule

// ===== src/fixed_point_perspective_projector_unit.sv =====
// Top level of the perspective projector: front end, queue, divider back end, result FIFO.
// Depends on fppu_pkg, fppu_front, fppu_queue, fppu_divider.
//
// Usage: write configuration through csr_we/csr_index/csr_wdata while idle.
// Push requests with req_push while req_full is low; one result per request
// appears on rsp_data while rsp_empty is low and is taken with rsp_pop.
// Throughput: one request per cycle while req_full is low. Path: 3 front stages,
// the work queue, 49 divider stages (one quotient bit per stage over
// a 48-bit numerator), then the result FIFO.
// The front and back pipelines advance independently; the back stalls only when the
// result FIFO lacks room for everything in flight, and the front stalls only
// when the work queue lacks room. req_full rises once queued plus in-flight
// work could exceed the free space, so no request is ever dropped.
// Reset is synchronous: it restores the identity matrix, zero offsets and
// screen distance 256 and empties every queue and pipeline.
// A stalled receiver fills the result FIFO, then the divider, the work queue and
// the front end, after which req_full holds.
module fixed_point_perspective_projector_unit #(
   parameter int unsigned WorkDepth = 8,
   parameter int unsigned RspDepth  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fppu_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fppu_pkg::CsrDataW-1:0] csr_wdata,
   input  logic                          req_push,
   input  fppu_pkg::req_type             req_data,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output fppu_pkg::rsp_type             rsp_data
);
   import fppu_pkg::*;
   localparam int unsigned DivLat = NumWidth + 1;
   localparam int unsigned CW = $clog2(RspDepth+1);
   localparam int unsigned WW = $clog2(WorkDepth+1);

   logic      f_valid, f_adv, b_adv, accept;
   work_type  f_data, q_data;
   qstat_type q_stat;
   logic [WW-1:0] q_count;
   logic      q_pop, d_valid;
   rsp_type   d_data;

   // in-flight tracking for the divider and the front end
   logic [CW-1:0] fly_ff;
   logic [CW-1:0] r_count;
   logic [WW-1:0] ffly_ff;

   // result FIFO
   rsp_type       rmem_ff [RspDepth];
   logic [$clog2(RspDepth)-1:0] rw_ff, rr_ff;
   logic [CW-1:0] rc_ff;
   logic [CW-1:0] mc_ff;
   rsp_type       head_ff;
   logic          head_valid_ff;
   logic r_push, r_pop;
   logic r_take, r_fetch, r_bypass, r_write;

   assign r_count = rc_ff;
   assign b_adv   = (32'(rc_ff) + 32'(fly_ff)) < RspDepth;
   assign q_pop   = b_adv && !q_stat.empty;
   assign f_adv   = (32'(q_count) + 32'(ffly_ff)) < WorkDepth;
   assign req_full = !f_adv;
   assign accept  = req_push && f_adv;

   fppu_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .in_valid(accept), .in_data(req_data), .advance(f_adv),
      .out_valid(f_valid), .out_data(f_data)
   );

   fppu_queue #(.Depth(WorkDepth)) u_queue (
      .clock, .reset, .push(f_valid && f_adv), .push_data(f_data),
      .pop(q_pop), .pop_data(q_data), .stat(q_stat), .count(q_count)
   );

   fppu_divider u_div (
      .clock, .reset, .advance(b_adv), .in_valid(q_pop), .in_data(q_data),
      .out_valid(d_valid), .out_data(d_data)
   );

   assign r_push   = d_valid && b_adv;
   assign r_pop    = rsp_pop && !rsp_empty;
   assign r_take   = !head_valid_ff || r_pop;
   assign r_fetch  = r_take && (mc_ff != '0);
   assign r_bypass = r_take && (mc_ff == '0) && r_push;
   assign r_write  = r_push && !r_bypass;

   always_ff @(posedge clock) begin
      if (reset) begin
         fly_ff        <= '0;
         ffly_ff       <= '0;
         rw_ff         <= '0;
         rr_ff         <= '0;
         rc_ff         <= '0;
         mc_ff         <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         fly_ff <= fly_ff + CW'(q_pop) - CW'(r_push);
         if (f_adv) ffly_ff <= ffly_ff + WW'(accept) - WW'(f_valid);
         if (r_write) rw_ff <= (rw_ff == ($clog2(RspDepth))'(RspDepth-1)) ? '0 : rw_ff + 1'b1;
         if (r_fetch) rr_ff <= (rr_ff == ($clog2(RspDepth))'(RspDepth-1)) ? '0 : rr_ff + 1'b1;
         rc_ff <= rc_ff + CW'(r_push) - CW'(r_pop);
         mc_ff <= mc_ff + CW'(r_write) - CW'(r_fetch);
         if (r_take) head_valid_ff <= r_fetch || r_bypass;
      end
   end

   always_ff @(posedge clock) begin
      if (r_write) rmem_ff[rw_ff] <= d_data;
      if (r_fetch) head_ff <= rmem_ff[rr_ff];
      else if (r_bypass) head_ff <= d_data;
   end

   assign rsp_empty = !head_valid_ff;
   assign rsp_data  = head_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(r_count) + 32'(fly_ff) <= RspDepth)
      else $error("result space overcommitted");
   assert property (@(posedge clock) disable iff (reset) fly_ff <= CW'(DivLat))
      else $error("divider occupancy");
   assert property (@(posedge clock) disable iff (reset) r_push |-> b_adv)
      else $error("result written during stall");
endmodule

// ===== tb/fppu_checker.sv =====
// Checker for the perspective projector: tracks configuration writes, predicts each
// projected point and compares it with the response stream.
// Depends on fppu_pkg.
module fppu_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fppu_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [fppu_pkg::CsrDataW-1:0] csr_wdata,
   input  logic                          req_push,
   input  fppu_pkg::req_type             req_data,
   input  logic                          req_full,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  fppu_pkg::rsp_type             rsp_data,
   output int                            fail_count,
   output int                            pending
);
   import fppu_pkg::*;

   logic [47:0] row0, row1, row2;
   logic [31:0] off_x, off_y, off_z;
   logic [15:0] distance;
   rsp_type     projected_q[$];

   function automatic logic [31:0] rotate_row(logic [47:0] row, req_type p, logic [31:0] off);
      longint acc;
      acc = longint'($signed(row[15:0])) * longint'(p.point_x)
          + longint'($signed(row[31:16])) * longint'(p.point_y)
          + longint'($signed(row[47:32])) * longint'(p.point_z);
      acc = acc >>> QShift;
      return acc[31:0] + off;
   endfunction

   function automatic logic [31:0] to_screen(logic [31:0] c, longint depth, logic [31:0] ctr);
      longint num;
      longint q;
      num = longint'($signed(c)) * longint'(distance);
      q = num / depth;
      return q[31:0] + ctr;
   endfunction

   function automatic rsp_type project_point(req_type p);
      rsp_type     r;
      logic [31:0] cx, cy, cz;
      longint      depth;
      cx = rotate_row(row0, p, off_x);
      cy = rotate_row(row1, p, off_y);
      cz = rotate_row(row2, p, off_z);
      depth = longint'($signed(cz));
      r = '0;
      if (depth > longint'(MinDepth)) begin
         r.visible  = 1'b1;
         r.screen_u = to_screen(cx, depth, CenterU);
         r.screen_v = to_screen(cy, depth, CenterV);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         row0 = 48'h0000_0000_1000;
         row1 = 48'h0000_1000_0000;
         row2 = 48'h1000_0000_0000;
         off_x = '0;
         off_y = '0;
         off_z = '0;
         distance = 16'd256;
         projected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (projected_q.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               fail_count++;
            end else begin
               want = projected_q.pop_front();
               if (rsp_data.visible !== want.visible) begin
                  $error("visible: expected %0d, got %0d", want.visible, rsp_data.visible);
                  fail_count++;
               end
               if (rsp_data.screen_u !== want.screen_u) begin
                  $error("screen_u: expected %0d, got %0d", want.screen_u, rsp_data.screen_u);
                  fail_count++;
               end
               if (rsp_data.screen_v !== want.screen_v) begin
                  $error("screen_v: expected %0d, got %0d", want.screen_v, rsp_data.screen_v);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full) projected_q.push_back(project_point(req_data));
         if (csr_we) begin
            case (csr_index)
               RegRow0: row0 = csr_wdata;
               RegRow1: row1 = csr_wdata;
               RegRow2: row2 = csr_wdata;
               RegOffX: off_x = csr_wdata[31:0];
               RegOffY: off_y = csr_wdata[31:0];
               RegOffZ: off_z = csr_wdata[31:0];
               RegDist: distance = csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      pending = projected_q.size();
   end

endmodule

// ===== tb/fixed_point_perspective_projector_unit_test.sv =====
// Testbench top for the perspective projector: drives configuration, points and
// response pops with random idling, and reports the verdict from fppu_checker.
// Depends on fppu_pkg, fppu_checker and fixed_point_perspective_projector_unit.
module fixed_point_perspective_projector_unit_test;
   import fppu_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;
   logic                req_push = 1'b0;
   req_type             req_data = '0;
   logic                req_full;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   rsp_type             rsp_data;
   int                  fail_count;
   int                  pending;
   bit                  steady_send;
   bit                  steady_pop;

   fixed_point_perspective_projector_unit uut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_push, .req_data, .req_full, .rsp_empty, .rsp_pop, .rsp_data
   );

   fppu_checker checker_inst (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_push, .req_data, .req_full, .rsp_empty, .rsp_pop, .rsp_data,
      .fail_count, .pending
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int gap;
      forever begin
         gap = steady_pop ? 0 : $urandom_range(12);
         if (gap > 0) begin
            @(negedge clock) rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      gap = steady_send ? 0 : $urandom_range(12);
      if (gap > 0) begin
         @(negedge clock) req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{point_x: x, point_y: y, point_z: z};
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock) req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(2000) - 1000;
         default: return $urandom_range(8) - 4;
      endcase
   endfunction

   function automatic logic [47:0] rand_row;
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[47:0];
   endfunction

   initial begin
      int mode;
      steady_send = 1'b0;
      steady_pop = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_point(0, 0, 0);
      send_point(0, 0, 1);
      send_point(0, 0, 2);
      send_point(5, -7, 2);
      send_point(100, 50, -3);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 2);
      send_point(32'h8000_0000, 32'h8000_0000, 3);
      send_point(1, 1, 32'h8000_0000);
      send_point(-1, -1, 32'hffff_ffff);
      drain();

      write_reg(RegRow0, 48'h7fff_7fff_7fff);
      write_reg(RegRow1, 48'h8000_8000_8000);
      write_reg(RegRow2, 48'h7fff_8000_7fff);
      write_reg(RegOffX, 48'h7fff_ffff);
      write_reg(RegOffY, 48'h8000_0000);
      write_reg(RegOffZ, 48'h7fff_ffff);
      write_reg(RegDist, 48'hffff);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(0, 0, 0);
      send_point(1000, -1000, 3);
      drain();
      write_reg(RegDist, 48'd0);
      write_reg(RegOffZ, 48'h8000_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_point(123, 456, 789);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_reg(RegRow0, 48'h0000_0000_1000);
               write_reg(RegRow1, 48'h0000_1000_0000);
               write_reg(RegRow2, 48'h1000_0000_0000);
               write_reg(RegOffX, 48'd0);
               write_reg(RegOffY, 48'd0);
               write_reg(RegOffZ, 48'd0);
               write_reg(RegDist, 48'd256);
            end
            1: write_reg(RegDist, 48'hffff);
            2: write_reg(RegDist, 48'd0);
            default: begin
               write_reg(RegRow0, rand_row());
               write_reg(RegRow1, rand_row());
               write_reg(RegRow2, rand_row());
               write_reg(RegOffX, 48'(phase[0] ? $urandom : $urandom_range(4000) - 2000));
               write_reg(RegOffY, 48'(phase[0] ? $urandom : $urandom_range(4000) - 2000));
               write_reg(RegOffZ, 48'($urandom_range(20000)));
               write_reg(RegDist, 48'(phase == 6 ? 32'hffff : $urandom_range(16'hffff)));
            end
         endcase
         for (int n = 0; n < 145; n++) begin
            if (n % 50 == 0) begin
               steady_send = ($urandom_range(3) == 0);
               steady_pop = ($urandom_range(3) == 0);
            end
            mode = $urandom_range(2);
            send_point(pick_coord(mode), pick_coord(mode),
                       mode == 0 ? $urandom : pick_coord(mode) + $urandom_range(3000));
         end
         drain();
      end

      steady_pop = 1'b0;
      drain();
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
